// File: design/rbol_pkg.sv
// Package for the ring buffer offset lookup: field widths, op codes and request/result types.
package rbol_pkg;

  // Default ring depth
  localparam int unsigned RING_DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned OFFSET_W = 20;

  // Op codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // Request fields
  typedef struct packed {
    logic                op;
    logic [HANDLE_W-1:0] entry_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFSET_W-1:0] find_offset;
  } rbol_req_t;

  // Result fields
  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] found_handle;
    logic [SIZE_W-1:0]   byte_in_entry;
  } rbol_res_t;

endpackage

// File: design/rbol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbol_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ring_buffer_offset_lookup_top.sv
// Top level of the ring buffer offset lookup: ring indices, entry RAM and find sequencer.
//
//  channel   | ports                     | handshake
//  ----------+---------------------------+-------------------------------------
//  request   | req_i                     | taken when start is high, busy low
//  result    | res_o                     | res_valid_o high for one cycle
//
// An add request never raises busy; it yields no result.
// A find request walks the stored entries (up to RING_DEPTH of them): the
// single RAM read port reads one entry per cycle, oldest first, stopping at
// the entry that holds the offset, or after the newest one if none does.
// The result is registered and shows in the cycle after the decision; busy
// drops in that same cycle. Reset empties the ring at once, no clearing pass.
// The receiver cannot stall: each result is taken in its strobe cycle.
module ring_buffer_offset_lookup_top #(
  parameter int unsigned RING_DEPTH = rbol_pkg::RING_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rbol_pkg::rbol_req_t req_i,
  output logic                res_valid_o,
  output rbol_pkg::rbol_res_t res_o
);

  localparam int unsigned IW     = $clog2(RING_DEPTH);
  localparam int unsigned CW     = $clog2(RING_DEPTH + 1);
  localparam int unsigned BASE_W = rbol_pkg::SIZE_W + CW;
  localparam int unsigned CMP_W  =
    ((BASE_W > rbol_pkg::OFFSET_W) ? BASE_W : rbol_pkg::OFFSET_W) + 1;
  localparam int unsigned ENT_W  = rbol_pkg::HANDLE_W + rbol_pkg::SIZE_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e                      state_q;
  logic [IW-1:0]               wr_idx_q;
  logic [IW-1:0]               rd_idx_q;
  logic                        full_q;
  logic [IW-1:0]               walk_idx_q;
  logic [CW-1:0]               left_q;
  logic [BASE_W-1:0]           base_q;
  logic [rbol_pkg::OFFSET_W-1:0] target_q;
  logic                        res_valid_q;
  rbol_pkg::rbol_res_t         res_q;

  logic                        accept;
  logic                        add_req;
  logic                        find_req;
  logic [IW-1:0]               wr_idx_nxt;
  logic [IW-1:0]               rd_idx_nxt;
  logic [CW-1:0]               count;
  logic [IW-1:0]               ram_raddr;
  logic [ENT_W-1:0]            ram_rdata;
  logic [rbol_pkg::HANDLE_W-1:0] ent_handle;
  logic [rbol_pkg::SIZE_W-1:0] ent_size;
  logic [CMP_W-1:0]            sum;
  logic                        hit;
  logic [CMP_W-1:0]            rel;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + IW'(1);
  endfunction

  // Request decode
  assign accept   = start && (state_q == ST_IDLE);
  assign add_req  = accept && (req_i.op == rbol_pkg::OP_ADD);
  assign find_req = accept && (req_i.op == rbol_pkg::OP_FIND);
  assign busy     = (state_q != ST_IDLE);

  // Ring occupancy
  always_comb begin
    if (full_q) begin
      count = DEPTH_C;
    end else if (wr_idx_q >= rd_idx_q) begin
      count = CW'(wr_idx_q) - CW'(rd_idx_q);
    end else begin
      count = DEPTH_C - CW'(rd_idx_q) + CW'(wr_idx_q);
    end
  end

  // Index update on add
  assign wr_idx_nxt = ring_next(wr_idx_q);
  assign rd_idx_nxt = full_q ? ring_next(rd_idx_q) : rd_idx_q;

  // Entry store: handle and size side by side
  assign ram_raddr = (state_q == ST_IDLE) ? rd_idx_q : walk_idx_q;

  rbol_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (add_req),
    .waddr_i (wr_idx_q),
    .wdata_i ({req_i.entry_handle, req_i.entry_size}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent_handle = ram_rdata[ENT_W-1 -: rbol_pkg::HANDLE_W];
  assign ent_size   = ram_rdata[rbol_pkg::SIZE_W-1:0];

  // Shared compare: does the offset fall before the end of this entry
  assign sum = CMP_W'(base_q) + CMP_W'(ent_size);
  assign hit = CMP_W'(target_q) < sum;
  assign rel = CMP_W'(target_q) - CMP_W'(base_q);

  // Sequencer, ring indices and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      full_q      <= 1'b0;
      walk_idx_q  <= '0;
      left_q      <= '0;
      base_q      <= '0;
      target_q    <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (add_req) begin
            wr_idx_q <= wr_idx_nxt;
            rd_idx_q <= rd_idx_nxt;
            if (wr_idx_nxt == rd_idx_nxt) begin
              full_q <= 1'b1;
            end
          end else if (find_req) begin
            target_q   <= req_i.find_offset;
            base_q     <= '0;
            left_q     <= count;
            walk_idx_q <= ring_next(rd_idx_q);
            if (count == '0) begin
              // empty ring: not found at once
              res_valid_q <= 1'b1;
              res_q       <= '0;
            end else begin
              state_q <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (hit) begin
            res_valid_q         <= 1'b1;
            res_q.found         <= 1'b1;
            res_q.found_handle  <= ent_handle;
            res_q.byte_in_entry <= rel[rbol_pkg::SIZE_W-1:0];
            state_q             <= ST_IDLE;
          end else if (left_q == CW'(1)) begin
            // walked past the newest entry
            res_valid_q <= 1'b1;
            res_q       <= '0;
            state_q     <= ST_IDLE;
          end else begin
            base_q     <= sum[BASE_W-1:0];
            left_q     <= left_q - CW'(1);
            walk_idx_q <= ring_next(walk_idx_q);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: design/rbol_checker.sv
// Port-level checker for the ring buffer offset lookup, bound to the top level.
module rbol_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input rbol_pkg::rbol_req_t req_i,
  input logic                res_valid_o,
  input rbol_pkg::rbol_res_t res_o
);

  // A miss reports zero handle and zero byte offset
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.found) |->
      (res_o.found_handle == '0 && res_o.byte_in_entry == '0))
    else $error("not-found result carries non-zero fields");

  // An add request never produces a result
  a_add_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == rbol_pkg::OP_ADD) |=> !res_valid_o)
    else $error("result appeared after an add request");

  // A find request either walks or answers straight away
  a_find_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == rbol_pkg::OP_FIND) |=> (busy || res_valid_o))
    else $error("find request neither walking nor answered");

  // The end of a walk always delivers its result
  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("walk finished without a result");

  // Busy only rises after a find request
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> ($past(start) && $past(req_i.op) == rbol_pkg::OP_FIND))
    else $error("busy rose without a find request");

endmodule

bind ring_buffer_offset_lookup_top rbol_checker u_rbol_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
